FILE: sv/utf8v_pkg.sv
// Shared types and constants for the UTF-8 text string validator.
// No dependencies; imported by every module of the block.
package utf8v_pkg;

  localparam int unsigned CountW   = 17;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned ValueW   = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LimitW-1:0] MaxCodepointsReset = 16'd255;

  localparam logic [7:0] LeadMask2 = 8'he0;
  localparam logic [7:0] LeadCode2 = 8'hc0;
  localparam logic [7:0] LeadMask3 = 8'hf0;
  localparam logic [7:0] LeadCode3 = 8'he0;
  localparam logic [7:0] LeadMask4 = 8'hf8;
  localparam logic [7:0] LeadCode4 = 8'hf0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] AsciiMax  = 8'h7f;
  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [7:0] ByteDel   = 8'h7f;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteLf    = 8'h0a;

  localparam logic [ValueW-1:0] Floor2      = 21'h80;
  localparam logic [ValueW-1:0] Floor3      = 21'h800;
  localparam logic [ValueW-1:0] Floor4      = 21'h10000;
  localparam logic [ValueW-1:0] ValueMax    = 21'h10ffff;
  localparam logic [ValueW-1:0] SurrogateLo = 21'hd800;
  localparam logic [ValueW-1:0] SurrogateHi = 21'hdfff;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxCodepoints   = 2'd0,
    CfgAllowLineBreaks = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadUtf8 = 2'd1,
    StatusBadCnt  = 2'd2,
    StatusControl = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] codepoint_count;
  } out_item_t;

  typedef struct packed {
    logic [LimitW-1:0] max_codepoints;
    logic              allow_line_breaks;
  } cfg_t;

endpackage

FILE: sv/utf8_text_validator.sv
// Top level of the UTF-8 text string validator: input register, config
// registers, output register. Depends on utf8v_pkg and utf8v_core.

// Takes one byte of a text string per cycle unless the input is stalled,
// with a last mark on the final byte, and gives one verdict (status and
// codepoint count) per string. A byte is captured in an input register;
// the decode step between that register and the output register updates
// the string state; the verdict is written to the output register as the
// last byte steps on. The input stalls only when a last byte is waiting and
// the previous verdict is still held by a stalled output. Config writes are
// always ready and must be made while no string is in flight.
module utf8_text_validator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  utf8v_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output utf8v_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [utf8v_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [utf8v_pkg::CfgDataW-1:0]      cfg_data_i
);
  import utf8v_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      step;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_codepoints    <= MaxCodepointsReset;
      cfg_q.allow_line_breaks <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaxCodepoints:   cfg_q.max_codepoints    <= cfg_data_i[LimitW-1:0];
        CfgAllowLineBreaks: cfg_q.allow_line_breaks <= cfg_data_i[0];
        default:            ;
      endcase
    end
  end

  // a last byte needs a free output slot to advance
  assign step       = s1_valid_q && (!s1_item_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_data_i;
    end
  end

  utf8v_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && s1_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_item_q.last) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

FILE: sv/utf8v_core.sv
// Per-string decode state and verdict logic of the UTF-8 validator.
// Depends on utf8v_pkg.
module utf8v_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  utf8v_pkg::in_item_t item_i,
  input  utf8v_pkg::cfg_t     cfg_i,
  output utf8v_pkg::out_item_t result_o
);
  import utf8v_pkg::*;

  logic [1:0]        pending_q, pending_d;
  logic [1:0]        seq_len_q, seq_len_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [CountW-1:0] count_q, count_d;
  logic              bad_q, bad_d;
  logic              ctrl_q, ctrl_d;

  always_comb begin
    logic [7:0]        b;
    logic              ctrl_n;
    logic              bad_n;
    logic              do_count;
    logic [1:0]        pend_n;
    logic [1:0]        len_n;
    logic [ValueW-1:0] val_n;
    logic [ValueW-1:0] floor_v;
    logic [CountW-1:0] cnt_n;
    logic              bad_f;

    b        = item_i.data_byte;
    ctrl_n   = ctrl_q;
    bad_n    = bad_q;
    do_count = 1'b0;
    pend_n   = pending_q;
    len_n    = seq_len_q;
    val_n    = value_q;
    floor_v  = Floor4;

    if ((b < CtrlLimit) || (b == ByteDel)) begin
      if (!(((b == ByteTab) || (b == ByteLf)) && cfg_i.allow_line_breaks)) begin
        ctrl_n = 1'b1;
      end
    end

    if (!bad_q) begin
      if (pending_q == 2'd0) begin
        if (b <= AsciiMax) begin
          do_count = 1'b1;
        end else if ((b & LeadMask2) == LeadCode2) begin
          val_n  = {16'd0, b[4:0]};
          len_n  = 2'd1;
          pend_n = 2'd1;
        end else if ((b & LeadMask3) == LeadCode3) begin
          val_n  = {17'd0, b[3:0]};
          len_n  = 2'd2;
          pend_n = 2'd2;
        end else if ((b & LeadMask4) == LeadCode4) begin
          val_n  = {18'd0, b[2:0]};
          len_n  = 2'd3;
          pend_n = 2'd3;
        end else begin
          bad_n = 1'b1;
        end
      end else if ((b & ContMask) != ContCode) begin
        bad_n = 1'b1;
      end else begin
        val_n  = {value_q[ValueW-7:0], b[5:0]};
        pend_n = pending_q - 2'd1;
        if (pend_n == 2'd0) begin
          unique case (seq_len_q)
            2'd1:    floor_v = Floor2;
            2'd2:    floor_v = Floor3;
            default: floor_v = Floor4;
          endcase
          if ((val_n < floor_v) || (val_n > ValueMax) ||
              ((val_n >= SurrogateLo) && (val_n <= SurrogateHi))) begin
            bad_n = 1'b1;
          end else begin
            do_count = 1'b1;
          end
        end
      end
    end

    // counter stops one above the limit
    cnt_n = count_q;
    if (do_count && (count_q <= {1'b0, cfg_i.max_codepoints})) begin
      cnt_n = count_q + CountW'(1);
    end

    // unfinished sequence at the end of the string is a fault
    bad_f = bad_n || (pend_n != 2'd0);

    result_o.codepoint_count = cnt_n;
    if (bad_f) begin
      result_o.status = StatusBadUtf8;
    end else if ((cnt_n == '0) || (cnt_n > {1'b0, cfg_i.max_codepoints})) begin
      result_o.status = StatusBadCnt;
    end else if (ctrl_n) begin
      result_o.status = StatusControl;
    end else begin
      result_o.status = StatusOk;
    end

    pending_d = pending_q;
    seq_len_d = seq_len_q;
    value_d   = value_q;
    count_d   = count_q;
    bad_d     = bad_q;
    ctrl_d    = ctrl_q;
    if (step_i) begin
      if (item_i.last) begin
        pending_d = '0;
        seq_len_d = '0;
        value_d   = '0;
        count_d   = '0;
        bad_d     = 1'b0;
        ctrl_d    = 1'b0;
      end else begin
        pending_d = pend_n;
        seq_len_d = len_n;
        value_d   = val_n;
        count_d   = cnt_n;
        bad_d     = bad_n;
        ctrl_d    = ctrl_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seq_len_q <= '0;
      value_q   <= '0;
      count_q   <= '0;
      bad_q     <= 1'b0;
      ctrl_q    <= 1'b0;
    end else begin
      pending_q <= pending_d;
      seq_len_q <= seq_len_d;
      value_q   <= value_d;
      count_q   <= count_d;
      bad_q     <= bad_d;
      ctrl_q    <= ctrl_d;
    end
  end

endmodule

FILE: sv/utf8v_checker.sv
// Port-level checks for utf8_text_validator, attached by bind.
// Depends on utf8v_pkg.
module utf8v_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input utf8v_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input utf8v_pkg::out_item_t out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);
  import utf8v_pkg::*;

  // held verdict stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled verdict changed or dropped");

  // with no verdict pending, input is never stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a passing string has a nonzero count within the 16-bit limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StatusOk) |->
      (out_data_o.codepoint_count != '0) && !out_data_o.codepoint_count[CountW-1])
    else $error("ok verdict with out-of-range count");

  // a last byte accepted into an empty pipe yields a verdict through the input and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last && !out_valid_o && !$past(in_valid_i)
      |-> ##2 out_valid_o)
    else $error("verdict missing after last byte");

  assert property (@(posedge clk_i) cfg_valid_i |-> cfg_ready_o)
    else $error("config port not ready");

endmodule

bind utf8_text_validator utf8v_checker u_checker (.*);

FILE: bench/utf8_text_validator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_text_validator: directed table, then random strings.
// Depends on utf8v_pkg and the utf8_text_validator RTL only.
module utf8_text_validator_tb;
  import utf8v_pkg::*;

  localparam int PhaseCount    = 6;
  localparam int PhaseBytes    = 320;
  localparam int HoldCycles    = 250;
  localparam int DrainCycles   = 6;
  localparam int WatchdogLimit = 3000;
  localparam int MaxReports    = 10;
  localparam int DirRows       = 28;

  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  always #10 clk = ~clk;

  utf8_text_validator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Decoder shadow: register copies and per-string state.
  logic [LimitW-1:0] lim_reg;
  logic              lb_reg;
  logic [1:0]        pend_cnt;
  logic [1:0]        seq_len;
  logic [ValueW-1:0] cp_value;
  logic [CountW-1:0] cp_count;
  bit                utf8_bad;
  bit                ctrl_seen;

  out_item_t verdict_q[$];

  int fail_cnt      = 0;
  int bytes_sent    = 0;
  int strings_sent  = 0;
  int verdicts_seen = 0;
  int status_seen[4];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  typedef struct {
    logic [7:0]        data_byte;
    bit                last;
    bit                typed;
    status_e           status;
    logic [CountW-1:0] count;
  } dir_row_t;

  dir_row_t dir_tab [DirRows] = '{
    '{8'h41, 1'b1, 1'b1, StatusOk,      17'd1},
    '{8'h7f, 1'b1, 1'b1, StatusControl, 17'd1},
    '{8'hff, 1'b1, 1'b1, StatusBadUtf8, 17'd0},
    '{8'hc3, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'ha9, 1'b1, 1'b1, StatusOk,      17'd1},
    // overlong two-byte form
    '{8'hc0, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h80, 1'b1, 1'b1, StatusBadUtf8, 17'd0},
    '{8'he2, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h82, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'hac, 1'b1, 1'b1, StatusOk,      17'd1},
    // surrogate
    '{8'hed, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'ha0, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h80, 1'b1, 1'b1, StatusBadUtf8, 17'd0},
    // just above 0x10FFFF
    '{8'hf4, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h90, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h80, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h80, 1'b1, 1'b1, StatusBadUtf8, 17'd0},
    '{8'hf0, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h9f, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h98, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h80, 1'b1, 1'b1, StatusOk,      17'd1},
    // truncated three-byte sequence
    '{8'he2, 1'b1, 1'b1, StatusBadUtf8, 17'd0},
    '{8'h09, 1'b1, 1'b1, StatusControl, 17'd1},
    // control byte after a fault: count frozen, bad UTF-8 wins
    '{8'h41, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'hff, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h00, 1'b1, 1'b0, StatusOk,      17'd0},
    '{8'hc3, 1'b0, 1'b0, StatusOk,      17'd0},
    '{8'h41, 1'b1, 1'b1, StatusBadUtf8, 17'd0}
  };

  task automatic log_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic clear_string();
    pend_cnt  = '0;
    seq_len   = '0;
    cp_value  = '0;
    cp_count  = '0;
    utf8_bad  = 0;
    ctrl_seen = 0;
  endtask

  task automatic bump_count();
    if (cp_count <= {1'b0, lim_reg}) cp_count = cp_count + 1'b1;
  endtask

  task automatic decode_byte(input in_item_t it, output bit has_res, output out_item_t res);
    logic [7:0]        b;
    logic [ValueW-1:0] floor_v;
    b = it.data_byte;
    res = '0;
    if (b < CtrlLimit || b == ByteDel) begin
      if (!((b == ByteTab || b == ByteLf) && lb_reg)) ctrl_seen = 1;
    end
    if (!utf8_bad) begin
      if (pend_cnt == 0) begin
        if (b <= AsciiMax) begin
          bump_count();
        end else if ((b & LeadMask2) == LeadCode2) begin
          cp_value = ValueW'(b[4:0]);
          seq_len  = 2'd1;
          pend_cnt = 2'd1;
        end else if ((b & LeadMask3) == LeadCode3) begin
          cp_value = ValueW'(b[3:0]);
          seq_len  = 2'd2;
          pend_cnt = 2'd2;
        end else if ((b & LeadMask4) == LeadCode4) begin
          cp_value = ValueW'(b[2:0]);
          seq_len  = 2'd3;
          pend_cnt = 2'd3;
        end else begin
          utf8_bad = 1;
        end
      end else if ((b & ContMask) != ContCode) begin
        utf8_bad = 1;
      end else begin
        cp_value = {cp_value[ValueW-7:0], b[5:0]};
        pend_cnt = pend_cnt - 1'b1;
        if (pend_cnt == 0) begin
          case (seq_len)
            2'd1:    floor_v = Floor2;
            2'd2:    floor_v = Floor3;
            default: floor_v = Floor4;
          endcase
          if (cp_value < floor_v || cp_value > ValueMax ||
              (cp_value >= SurrogateLo && cp_value <= SurrogateHi))
            utf8_bad = 1;
          else
            bump_count();
        end
      end
    end
    has_res = it.last;
    if (it.last) begin
      if (!utf8_bad && pend_cnt != 0) utf8_bad = 1;
      if (utf8_bad)                                         res.status = StatusBadUtf8;
      else if (cp_count == 0 || cp_count > {1'b0, lim_reg}) res.status = StatusBadCnt;
      else if (ctrl_seen)                                   res.status = StatusControl;
      else                                                  res.status = StatusOk;
      res.codepoint_count = cp_count;
      clear_string();
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgMaxCodepoints)        lim_reg = val;
    else if (idx == CfgAllowLineBreaks) lb_reg  = val[0];
  endtask

  task automatic apply_config(input logic [LimitW-1:0] lim, input bit lb);
    write_reg(CfgMaxCodepoints, lim);
    write_reg(CfgAllowLineBreaks, CfgDataW'(lb));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input out_item_t typed_res);
    in_item_t  it;
    bit        has_res;
    out_item_t res;
    it.data_byte = b;
    it.last      = last;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    decode_byte(it, has_res, res);
    if (has_res) verdict_q = {verdict_q, (typed ? typed_res : res)};
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_string(ref logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1, 1'b0, '0);
  endtask

  task automatic push_codepoint(ref logic [7:0] s[$]);
    int                r;
    logic [ValueW-1:0] v;
    r = $urandom_range(99);
    if (r < 40) begin
      s = {s, 8'($urandom_range(8'h7e, 8'h20))};
    end else if (r < 48) begin
      case ($urandom_range(3))
        0:       s = {s, ByteTab};
        1:       s = {s, ByteLf};
        2:       s = {s, ByteDel};
        default: s = {s, 8'($urandom_range(8'h1f))};
      endcase
    end else if (r < 68) begin
      v = ValueW'($urandom_range(21'h7ff, 21'h80));
      s = {s, {3'b110, v[10:6]}, {2'b10, v[5:0]}};
    end else if (r < 86) begin
      v = ValueW'($urandom_range(21'hffff, 21'h800));
      if (v >= SurrogateLo && v <= SurrogateHi) v = v - 21'h800;
      s = {s, {4'b1110, v[15:12]}, {2'b10, v[11:6]}, {2'b10, v[5:0]}};
    end else begin
      v = ValueW'($urandom_range(21'h10ffff, 21'h10000));
      s = {s, {5'b11110, v[20:18]}, {2'b10, v[17:12]}, {2'b10, v[11:6]}, {2'b10, v[5:0]}};
    end
  endtask

  task automatic break_string(ref logic [7:0] s[$]);
    int kind;
    kind = $urandom_range(3);
    case (kind)
      0: s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
      1: begin
        // unfinished sequence at the end
        case ($urandom_range(2))
          0:       s = {s, 8'hc2};
          1:       s = {s, 8'he1, 8'h80};
          default: s = {s, 8'hf1, 8'h80, 8'h80};
        endcase
      end
      2: begin
        case ($urandom_range(6))
          0:       s = {s, 8'hc1, 8'hbf};
          1:       s = {s, 8'he0, 8'h9f, 8'hbf};
          2:       s = {s, 8'hf0, 8'h8f, 8'hbf, 8'hbf};
          3:       s = {s, 8'hed, 8'hb0, 8'h80};
          4:       s = {s, 8'hf4, 8'h90, 8'h80, 8'h80};
          5:       s = {s, 8'($urandom_range(8'hff, 8'hf8))};
          default: s = {s, 8'($urandom_range(8'hbf, 8'h80))};
        endcase
      end
      default: repeat ($urandom_range(6, 1)) s = {s, 8'($urandom_range(255))};
    endcase
    if (kind != 1 && $urandom_range(1)) repeat ($urandom_range(3, 1)) push_codepoint(s);
  endtask

  task automatic wait_drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      status_seen[out_data.status]++;
      if (verdict_q.size() == 0) begin
        log_fail($sformatf("verdict with none pending: status %0d count %0d",
                           out_data.status, out_data.codepoint_count));
      end else begin
        want = verdict_q.pop_front();
        if (out_data.status !== want.status || out_data.codepoint_count !== want.codepoint_count)
          log_fail($sformatf("verdict mismatch: want status %0d count %0d, got status %0d count %0d",
                             want.status, want.codepoint_count,
                             out_data.status, out_data.codepoint_count));
      end
    end
  end

  // Receiver: random stall plus a single long hold-off.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HoldCycles;
      hold_taken = 1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any request moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no progress for %0d cycles, %0d verdicts pending",
                 quiet_cycles, verdict_q.size());
        $display("utf8_text_validator verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] str_q[$];
    out_item_t  typed_res;
    int         max_n;
    int         phase_start;
    logic [LimitW-1:0] ph_lim;
    bit         ph_lb;
    bit         hold_done;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    lim_reg   = MaxCodepointsReset;
    lb_reg    = 1'b0;
    clear_string();
    hold_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed table under the reset register values.
    foreach (dir_tab[i]) begin
      typed_res.status          = dir_tab[i].status;
      typed_res.codepoint_count = dir_tab[i].count;
      send_byte(dir_tab[i].data_byte, dir_tab[i].last, dir_tab[i].typed, typed_res);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < PhaseCount; p++) begin
      wait_drain();
      case (p)
        0: begin ph_lim = 16'd255;   ph_lb = 0; end
        1: begin ph_lim = 16'd0;     ph_lb = 0; end
        2: begin ph_lim = 16'd1;     ph_lb = 1; end
        3: begin ph_lim = 16'hffff;  ph_lb = 1; end
        4: begin ph_lim = 16'd3;     ph_lb = 0; end
        default: begin
          ph_lim = LimitW'($urandom_range(20, 1));
          ph_lb  = $urandom_range(1);
        end
      endcase
      if (p == 0) begin
        // unmapped indexes must leave both registers alone
        write_reg(CfgSpare2, CfgDataW'($urandom_range(16'hffff)));
        write_reg(CfgSpare3, CfgDataW'($urandom_range(16'hffff)));
      end
      apply_config(ph_lim, ph_lb);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      max_n = (int'(ph_lim) + 3 > 12) ? 12 : int'(ph_lim) + 3;
      phase_start = bytes_sent;
      if (p == 0) begin
        // one string past the limit so the count saturates
        str_q.delete();
        repeat (int'(ph_lim) + 2) str_q = {str_q, 8'($urandom_range(8'h7e, 8'h20))};
        send_string(str_q);
      end
      while (bytes_sent - phase_start < PhaseBytes) begin
        str_q.delete();
        repeat ($urandom_range(max_n, 1)) push_codepoint(str_q);
        if ($urandom_range(99) < 15) break_string(str_q);
        send_string(str_q);
        if (p == 2 && !hold_done && bytes_sent - phase_start >= 40) begin
          hold_req  = 1;
          hold_done = 1;
        end
      end
      in_valid <= 1'b0;
    end

    wait_drain();
    $display("Covered %0d strings / %0d bytes over %0d register settings, limits 0..65535.",
             strings_sent, bytes_sent, PhaseCount + 1);
    $display("Verdicts ok/utf8/count/control: %0d/%0d/%0d/%0d, mismatches: %0d",
             status_seen[StatusOk], status_seen[StatusBadUtf8], status_seen[StatusBadCnt],
             status_seen[StatusControl], fail_cnt);
    if (fail_cnt == 0) begin
      $display("utf8_text_validator verification clean");
    end else begin
      $display("utf8_text_validator verification failed");
    end
    $finish;
  end

endmodule
